>>> hdl/cmrg_pkg.sv
// Shared types and constants of the combined recursive random generator.
`timescale 1ns / 1ps
`default_nettype none

package cmrg_pkg;

	localparam logic [30:0] MOD_ONE       = 31'd2147483647;
	localparam logic [30:0] MOD_TWO       = 31'd2145483479;
	// 2^31 mod MOD_TWO
	localparam logic [20:0] FOLD_TWO      = 21'd2000169;
	localparam logic [15:0] MUL_ONE_B     = 16'd63308;
	localparam logic [17:0] MUL_ONE_C     = 18'd183326;
	localparam logic [16:0] MUL_TWO_A     = 17'd86098;
	localparam logic [19:0] MUL_TWO_C     = 20'd539608;
	localparam logic [31:0] SEED_LIMIT    = 32'd2145483478;
	localparam logic [30:0] SEED_FALLBACK = 31'd1234567890;
	localparam int          SEED_WORDS    = 6;

	localparam logic KIND_SEED = 1'b0;
	localparam logic KIND_DRAW = 1'b1;

	localparam logic [30:0] FIRST_RST_0  = 31'd12345;
	localparam logic [30:0] FIRST_RST_1  = 31'd67890;
	localparam logic [30:0] FIRST_RST_2  = 31'd13579;
	localparam logic [30:0] SECOND_RST_0 = 31'd24680;
	localparam logic [30:0] SECOND_RST_1 = 31'd98765;
	localparam logic [30:0] SECOND_RST_2 = 31'd43210;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEED,
		ST_FOLD,
		ST_FOLD2,
		ST_REDUCE,
		ST_DIFF,
		ST_COMBINE
	} cmrg_state_t;

	typedef struct packed {
		logic capture;
		logic seed_load;
		logic seed_step;
		logic fold;
		logic fold2;
		logic reduce;
		logic diff;
		logic combine;
	} cmrg_cmd_t;

endpackage

`default_nettype wire

>>> hdl/combined_mrg_random_generator_core.sv
// Top level of the combined recursive random generator.
`timescale 1ns / 1ps
`default_nettype none

// Combined multiple recursive generator with two order-3 components (moduli
// 2^31-1 and 2145483479). A request with kind 1 draws one value h in 1..2^31-1,
// read as the 0.31 fraction h*2^-31; a request with kind 0 loads all six
// history words from seed and gives no result. The cycle that accepts a draw
// forms the four constant products, then two folding steps, a conditional
// subtract, and two modular differences run one per cycle in the shared
// datapath. A seed runs six chained rotate-and-replace steps. A finished
// result waits in the output register while the next request is taken; a draw
// holds in its last step only while that register is full and out_ready is low.
module combined_mrg_random_generator_core
	import cmrg_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        kind,
	input  wire logic [31:0] seed,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic      [30:0] random_value
);

	cmrg_cmd_t cmd;

	cmrg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.kind      (kind),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	cmrg_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.seed         (seed),
		.random_value (random_value)
	);

endmodule

`default_nettype wire

>>> hdl/cmrg_ctrl.sv
// Sequencer for seed and draw requests, with the output handshake.
`timescale 1ns / 1ps
`default_nettype none

module cmrg_ctrl
	import cmrg_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire logic      kind,
	output logic           out_valid,
	input  wire logic      out_ready,
	output cmrg_cmd_t      cmd
);

	cmrg_state_t state_q, state_d;
	logic [2:0]  seed_cnt_q;
	logic        out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			seed_cnt_q  <= 3'd0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			seed_cnt_q  <= cmd.seed_step ? seed_cnt_q + 3'd1 : 3'd0;
			out_valid_q <= cmd.combine | (out_valid_q & ~out_ready);
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (kind == KIND_DRAW) begin
						cmd.capture = 1'b1;
						state_d     = ST_FOLD;
					end else begin
						cmd.seed_load = 1'b1;
						state_d       = ST_SEED;
					end
				end
			end
			ST_SEED: begin
				cmd.seed_step = 1'b1;
				if (seed_cnt_q == 3'(SEED_WORDS - 1))
					state_d = ST_IDLE;
			end
			ST_FOLD: begin
				cmd.fold = 1'b1;
				state_d  = ST_FOLD2;
			end
			ST_FOLD2: begin
				cmd.fold2 = 1'b1;
				state_d   = ST_REDUCE;
			end
			ST_REDUCE: begin
				cmd.reduce = 1'b1;
				state_d    = ST_DIFF;
			end
			ST_DIFF: begin
				cmd.diff = 1'b1;
				state_d  = ST_COMBINE;
			end
			ST_COMBINE: begin
				if (!out_valid_q || out_ready) begin
					cmd.combine = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

>>> hdl/cmrg_datapath.sv
// Histories, modular product reduction and output register.
`timescale 1ns / 1ps
`default_nettype none

module cmrg_datapath
	import cmrg_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cmrg_cmd_t   cmd,
	input  wire logic [31:0] seed,
	output logic      [30:0] random_value
);

	function automatic logic [30:0] roll_word(input logic [31:0] w);
		logic [31:0] r;
		r = {w[30:0], w[31]};
		if (r == 32'd0 || r >= SEED_LIMIT)
			return SEED_FALLBACK;
		return r[30:0];
	endfunction

	// a, b below m; gives (a - b) mod m
	function automatic logic [30:0] sub_mod(input logic [30:0] a, input logic [30:0] b,
		input logic [30:0] m);
		logic [31:0] d;
		logic [31:0] w;
		d = {1'b0, a} - {1'b0, b};
		w = d + {1'b0, m};
		return (a >= b) ? d[30:0] : w[30:0];
	endfunction

	// s below 2*m
	function automatic logic [30:0] red_once(input logic [31:0] s, input logic [30:0] m);
		logic [31:0] d;
		d = s - {1'b0, m};
		return (s >= {1'b0, m}) ? d[30:0] : s[30:0];
	endfunction

	logic [30:0] first_q  [3];
	logic [30:0] second_q [3];
	logic [31:0] roll_q;
	logic [30:0] roll_w;

	logic [46:0] p1_q;
	logic [48:0] q1_q;
	logic [47:0] p2_q;
	logic [50:0] q2_q;

	logic [31:0] sum_p1_q, sum_q1_q;
	logic [38:0] t_p2_q;
	logic [41:0] t_q2_q;

	logic [30:0] red_p1_q, red_q1_q;
	logic [31:0] u_p2_q, u_q2_q;

	logic [30:0] red_p2_q, red_q2_q;
	logic [30:0] nx_q, ny_q;
	logic [30:0] h_d;
	logic [30:0] random_value_q;

	logic [37:0] fold_p2;
	logic [40:0] fold_q2;
	logic [28:0] fold2_p2;
	logic [31:0] fold2_q2;

	assign roll_w   = roll_word(roll_q);
	assign fold_p2  = p2_q[47:31] * FOLD_TWO;
	assign fold_q2  = q2_q[50:31] * FOLD_TWO;
	assign fold2_p2 = t_p2_q[38:31] * FOLD_TWO;
	assign fold2_q2 = t_q2_q[41:31] * FOLD_TWO;

	always_comb begin
		h_d = sub_mod(nx_q, ny_q, MOD_ONE);
		if (h_d == 31'd0)
			h_d = MOD_ONE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q[0]  <= FIRST_RST_0;
			first_q[1]  <= FIRST_RST_1;
			first_q[2]  <= FIRST_RST_2;
			second_q[0] <= SECOND_RST_0;
			second_q[1] <= SECOND_RST_1;
			second_q[2] <= SECOND_RST_2;
		end else if (cmd.seed_step) begin
			first_q[0]  <= first_q[1];
			first_q[1]  <= first_q[2];
			first_q[2]  <= second_q[0];
			second_q[0] <= second_q[1];
			second_q[1] <= second_q[2];
			second_q[2] <= roll_w;
		end else if (cmd.combine) begin
			first_q[0]  <= first_q[1];
			first_q[1]  <= first_q[2];
			first_q[2]  <= nx_q;
			second_q[0] <= second_q[1];
			second_q[1] <= second_q[2];
			second_q[2] <= ny_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.seed_load)
			roll_q <= seed;
		else if (cmd.seed_step)
			roll_q <= {1'b0, roll_w};

		if (cmd.capture) begin
			p1_q <= first_q[1] * MUL_ONE_B;
			q1_q <= first_q[0] * MUL_ONE_C;
			p2_q <= second_q[2] * MUL_TWO_A;
			q2_q <= second_q[0] * MUL_TWO_C;
		end

		// 2^31 folds to 1 for the first modulus
		if (cmd.fold) begin
			sum_p1_q <= 32'(p1_q[46:31]) + 32'(p1_q[30:0]);
			sum_q1_q <= 32'(q1_q[48:31]) + 32'(q1_q[30:0]);
			t_p2_q   <= 39'(fold_p2) + 39'(p2_q[30:0]);
			t_q2_q   <= 42'(fold_q2) + 42'(q2_q[30:0]);
		end

		if (cmd.fold2) begin
			red_p1_q <= red_once(sum_p1_q, MOD_ONE);
			red_q1_q <= red_once(sum_q1_q, MOD_ONE);
			u_p2_q   <= 32'(fold2_p2) + 32'(t_p2_q[30:0]);
			u_q2_q   <= fold2_q2 + 32'(t_q2_q[30:0]);
		end

		if (cmd.reduce) begin
			nx_q     <= sub_mod(red_p1_q, red_q1_q, MOD_ONE);
			red_p2_q <= red_once(u_p2_q, MOD_TWO);
			red_q2_q <= red_once(u_q2_q, MOD_TWO);
		end

		if (cmd.diff)
			ny_q <= sub_mod(red_p2_q, red_q2_q, MOD_TWO);

		if (cmd.combine)
			random_value_q <= h_d;
	end

	assign random_value = random_value_q;

endmodule

`default_nettype wire
